// ----- sv/pwsr_pkg.sv -----
// Shared constants, payload types and arithmetic unit interface for the ramped PID block.
`default_nettype none
package pwsr_pkg;

    localparam int VALUE_WIDTH       = 32;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int DT_WIDTH          = 16;
    localparam int DT_FRAC           = 16;
    localparam int CAP_SHIFT         = 60;
    localparam int MAG_W             = CAP_SHIFT + 1;
    localparam int OPB_W             = VALUE_WIDTH + 1;
    localparam int SVAL_W            = MAG_W + 1;
    localparam int INTEG_W           = VALUE_WIDTH + 8;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE    = 3'd5;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] target;
        logic signed [VALUE_WIDTH-1:0] measurement;
        logic [DT_WIDTH-1:0]           step_time;
        logic                          clear;
    } pwsr_in_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] drive;
        logic                          clamped;
    } pwsr_out_t;

    typedef struct packed {
        logic             start;
        logic             divide;
        logic             frac_shift;
        logic [MAG_W-1:0] a_mag;
        logic [OPB_W-1:0] b_mag;
    } pwsr_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] mag;
    } pwsr_rsp_t;

endpackage
`default_nettype wire

// ----- sv/pid_with_setpoint_ramp.sv -----
// Top level: PID controller with rate-limited setpoint, clamp, anti-windup and deadband.
// A full step accepts one transaction at a time and runs its products and the derivative quotient
// in sequence on the shared bit-serial multiplier and the 77-step divider.
// The first pass after reset or clear skips the derivative.
// A clear or a zero step time skips the arithmetic and goes straight to the output; a waiting result stalls.
// Synchronous reset restores register defaults and clears the controller state.
`default_nettype none
module pid_with_setpoint_ramp #(
    parameter int FRAC_BITS = pwsr_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire pwsr_pkg::pwsr_in_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output pwsr_pkg::pwsr_out_t                      m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pwsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pwsr_pkg::VALUE_WIDTH-1:0]    cfg_data
);
    import pwsr_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int SW = SVAL_W;
    localparam int IW = INTEG_W;
    localparam int UW = SW + 2;

    localparam logic signed [SW:0] INT_MAX = {{(SW + 2 - IW){1'b0}}, {(IW - 1){1'b1}}};
    localparam logic signed [SW:0] INT_MIN = ~INT_MAX;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_MC    = 5'd1;
    localparam logic [4:0] ST_RAMP  = 5'd2;
    localparam logic [4:0] ST_ERR   = 5'd3;
    localparam logic [4:0] ST_P     = 5'd4;
    localparam logic [4:0] ST_I     = 5'd5;
    localparam logic [4:0] ST_INC   = 5'd6;
    localparam logic [4:0] ST_INT   = 5'd7;
    localparam logic [4:0] ST_D     = 5'd8;
    localparam logic [4:0] ST_DIV   = 5'd9;
    localparam logic [4:0] ST_SUM   = 5'd10;
    localparam logic [4:0] ST_CLAMP = 5'd11;
    localparam logic [4:0] ST_DEAD  = 5'd12;
    localparam logic [4:0] ST_DONE  = 5'd13;

    function automatic logic [VW:0] abs_v(input logic [VW:0] x);
        logic [VW:0] r;
        r = x[VW] ? (~x + 1'b1) : x;
        return r;
    endfunction

    function automatic logic signed [SW-1:0] apply_sign(input logic [MAG_W-1:0] m,
                                                        input logic neg);
        logic signed [SW-1:0] e;
        e = {1'b0, m};
        return neg ? -e : e;
    endfunction

    logic [4:0]              st_reg, st_next;
    logic                    go_reg, go_next;
    logic                    m_valid_reg;
    pwsr_out_t               m_data_reg;

    logic signed [VW-1:0]    gain_p_reg, gain_i_reg, gain_d_reg;
    logic [VW-2:0]           limit_reg, dead_reg, rate_reg;

    logic signed [IW-1:0]    integ_reg;
    logic signed [VW-1:0]    prev_err_reg, held_reg, ramp_reg;
    logic                    first_reg;

    logic signed [VW-1:0]    target_reg, meas_reg, err_reg, drive_reg;
    logic [DT_WIDTH-1:0]     dt_reg;
    logic [VW-2:0]           mc_reg;
    logic signed [SW-1:0]    p_val_reg, inc_reg, d_reg;
    logic [MAG_W-1:0]        tmp_mag_reg, t_mag_reg;
    logic                    tmp_neg_reg, t_neg_reg, clamped_reg;
    logic signed [IW-1:0]    old_int_reg;
    logic signed [UW-1:0]    u_reg;

    pwsr_req_t               req;
    pwsr_rsp_t               rsp;

    logic                    accept, out_free;
    logic signed [VW:0]      err_sp, mc_s, err_full, diff;
    logic signed [VW-1:0]    ramp_new, err_sat;
    logic signed [SW:0]      int_sum;
    logic signed [IW-1:0]    int_sat;
    logic signed [UW-1:0]    u_sum, lim_s;
    logic [VW-1:0]           neg_lim, drive_mag;
    logic                    err_pos, err_neg;

    assign s_ready   = (st_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    pwsr_arith #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    always_comb begin
        err_sp   = (VW + 1)'(target_reg) - (VW + 1)'(ramp_reg);
        mc_s     = {2'b00, mc_reg};
        if (err_sp > mc_s) begin
            ramp_new = ramp_reg + {1'b0, mc_reg};
        end else if (err_sp < -mc_s) begin
            ramp_new = ramp_reg - {1'b0, mc_reg};
        end else begin
            ramp_new = target_reg;
        end
        err_full = (VW + 1)'(ramp_reg) - (VW + 1)'(meas_reg);
        if (err_full[VW] != err_full[VW-1]) begin
            err_sat = err_full[VW] ? {1'b1, {(VW - 1){1'b0}}} : {1'b0, {(VW - 1){1'b1}}};
        end else begin
            err_sat = err_full[VW-1:0];
        end
        diff     = (VW + 1)'(err_reg) - (VW + 1)'(prev_err_reg);
        int_sum  = (SW + 1)'(integ_reg) + (SW + 1)'(inc_reg);
        if (int_sum > INT_MAX) begin
            int_sat = INT_MAX[IW-1:0];
        end else if (int_sum < INT_MIN) begin
            int_sat = INT_MIN[IW-1:0];
        end else begin
            int_sat = int_sum[IW-1:0];
        end
        u_sum     = UW'(p_val_reg) + UW'(integ_reg) + UW'(d_reg);
        lim_s     = {{(UW - VW + 1){1'b0}}, limit_reg};
        neg_lim   = {VW{1'b0}} - {1'b0, limit_reg};
        drive_mag = drive_reg[VW-1] ? ({VW{1'b0}} - drive_reg) : drive_reg;
        err_pos   = !err_reg[VW-1] && (err_reg != '0);
        err_neg   = err_reg[VW-1];
    end

    always_comb begin
        req.start      = go_reg;
        req.divide     = 1'b0;
        req.frac_shift = 1'b0;
        req.a_mag      = '0;
        req.b_mag      = '0;
        case (st_reg)
            ST_MC: begin
                req.a_mag = MAG_W'(rate_reg);
                req.b_mag = OPB_W'(dt_reg);
            end
            ST_P: begin
                req.frac_shift = 1'b1;
                req.a_mag      = MAG_W'(abs_v((VW + 1)'(gain_p_reg)));
                req.b_mag      = abs_v((VW + 1)'(err_reg));
            end
            ST_I: begin
                req.frac_shift = 1'b1;
                req.a_mag      = MAG_W'(abs_v((VW + 1)'(gain_i_reg)));
                req.b_mag      = abs_v((VW + 1)'(err_reg));
            end
            ST_INC: begin
                req.a_mag = tmp_mag_reg;
                req.b_mag = OPB_W'(dt_reg);
            end
            ST_D: begin
                req.frac_shift = 1'b1;
                req.a_mag      = MAG_W'(abs_v((VW + 1)'(gain_d_reg)));
                req.b_mag      = abs_v(diff);
            end
            ST_DIV: begin
                req.divide = 1'b1;
                req.a_mag  = t_mag_reg;
                req.b_mag  = OPB_W'(dt_reg);
            end
            default: begin
                req.a_mag = '0;
            end
        endcase
    end

    always_comb begin
        st_next = st_reg;
        go_next = 1'b0;
        case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.clear || (s_data.step_time == '0)) begin
                        st_next = ST_DONE;
                    end else begin
                        st_next = ST_MC;
                        go_next = 1'b1;
                    end
                end
            end
            ST_MC: begin
                if (rsp.done) begin
                    st_next = ST_RAMP;
                end
            end
            ST_RAMP: begin
                st_next = ST_ERR;
            end
            ST_ERR: begin
                st_next = ST_P;
                go_next = 1'b1;
            end
            ST_P: begin
                if (rsp.done) begin
                    st_next = ST_I;
                    go_next = 1'b1;
                end
            end
            ST_I: begin
                if (rsp.done) begin
                    st_next = ST_INC;
                    go_next = 1'b1;
                end
            end
            ST_INC: begin
                if (rsp.done) begin
                    st_next = ST_INT;
                end
            end
            ST_INT: begin
                if (first_reg) begin
                    st_next = ST_SUM;
                end else begin
                    st_next = ST_D;
                    go_next = 1'b1;
                end
            end
            ST_D: begin
                if (rsp.done) begin
                    st_next = ST_DIV;
                    go_next = 1'b1;
                end
            end
            ST_DIV: begin
                if (rsp.done) begin
                    st_next = ST_SUM;
                end
            end
            ST_SUM: begin
                st_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                st_next = ST_DEAD;
            end
            ST_DEAD: begin
                st_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    st_next = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            go_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            limit_reg    <= '1;
            dead_reg     <= '0;
            rate_reg     <= '1;
            integ_reg    <= '0;
            prev_err_reg <= '0;
            held_reg     <= '0;
            ramp_reg     <= '0;
            first_reg    <= 1'b1;
        end else begin
            st_reg <= st_next;
            go_reg <= go_next;
            if (st_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GAIN_P:       gain_p_reg <= cfg_data;
                    CFG_GAIN_I:       gain_i_reg <= cfg_data;
                    CFG_GAIN_D:       gain_d_reg <= cfg_data;
                    CFG_OUTPUT_LIMIT: limit_reg  <= cfg_data[VW-2:0];
                    CFG_DEAD_ZONE:    dead_reg   <= cfg_data[VW-2:0];
                    CFG_RAMP_RATE:    rate_reg   <= cfg_data[VW-2:0];
                    default:          limit_reg  <= limit_reg;
                endcase
            end
            case (st_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_data.clear) begin
                            integ_reg    <= '0;
                            prev_err_reg <= '0;
                            held_reg     <= '0;
                            ramp_reg     <= '0;
                            first_reg    <= 1'b1;
                        end else if (s_data.step_time != '0 && first_reg) begin
                            ramp_reg <= s_data.measurement;
                        end
                    end
                end
                ST_RAMP: begin
                    ramp_reg <= ramp_new;
                end
                ST_INT: begin
                    integ_reg <= int_sat;
                end
                ST_CLAMP: begin
                    if (u_reg > lim_s) begin
                        if (err_pos) begin
                            integ_reg <= old_int_reg;
                        end
                    end else if (u_reg < -lim_s) begin
                        if (err_neg) begin
                            integ_reg <= old_int_reg;
                        end
                    end
                end
                ST_DEAD: begin
                    held_reg     <= (drive_mag < {1'b0, dead_reg}) ? '0 : drive_reg;
                    prev_err_reg <= err_reg;
                    first_reg    <= 1'b0;
                end
                default: begin
                    first_reg <= first_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_DONE && out_free) begin
            m_data_reg.drive   <= drive_reg;
            m_data_reg.clamped <= clamped_reg;
        end
        case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    target_reg  <= s_data.target;
                    meas_reg    <= s_data.measurement;
                    dt_reg      <= s_data.step_time;
                    clamped_reg <= 1'b0;
                    drive_reg   <= s_data.clear ? '0 : held_reg;
                end
            end
            ST_MC: begin
                if (rsp.done) begin
                    mc_reg <= rsp.mag[VW-2:0];
                end
            end
            ST_ERR: begin
                err_reg <= err_sat;
            end
            ST_P: begin
                if (rsp.done) begin
                    p_val_reg <= apply_sign(rsp.mag, gain_p_reg[VW-1] ^ err_reg[VW-1]);
                end
            end
            ST_I: begin
                if (rsp.done) begin
                    tmp_mag_reg <= rsp.mag;
                    tmp_neg_reg <= gain_i_reg[VW-1] ^ err_reg[VW-1];
                end
            end
            ST_INC: begin
                if (rsp.done) begin
                    inc_reg <= apply_sign(rsp.mag, tmp_neg_reg);
                end
            end
            ST_INT: begin
                old_int_reg <= integ_reg;
                if (first_reg) begin
                    d_reg <= '0;
                end
            end
            ST_D: begin
                if (rsp.done) begin
                    t_mag_reg <= rsp.mag;
                    t_neg_reg <= gain_d_reg[VW-1] ^ diff[VW];
                end
            end
            ST_DIV: begin
                if (rsp.done) begin
                    d_reg <= apply_sign(rsp.mag, t_neg_reg);
                end
            end
            ST_SUM: begin
                u_reg <= u_sum;
            end
            ST_CLAMP: begin
                if (u_reg > lim_s) begin
                    drive_reg   <= {1'b0, limit_reg};
                    clamped_reg <= 1'b1;
                end else if (u_reg < -lim_s) begin
                    drive_reg   <= neg_lim;
                    clamped_reg <= 1'b1;
                end else begin
                    drive_reg   <= u_reg[VW-1:0];
                    clamped_reg <= 1'b0;
                end
            end
            ST_DEAD: begin
                if (drive_mag < {1'b0, dead_reg}) begin
                    drive_reg <= '0;
                end
            end
            default: begin
                dt_reg <= dt_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/pwsr_arith.sv -----
// Shared bit-serial multiply/round and divide unit working on magnitudes.
`default_nettype none
module pwsr_arith #(
    parameter int FRAC_BITS = pwsr_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire pwsr_pkg::pwsr_req_t req,
    output pwsr_pkg::pwsr_rsp_t      rsp
);
    import pwsr_pkg::*;

    localparam int AW        = MAG_W;
    localparam int BW        = OPB_W;
    localparam int PW        = AW + BW;
    localparam int DIV_STEPS = AW + DT_FRAC;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic [PW:0] HALF_F = (PW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [PW:0] HALF_T = (PW + 1)'(1) << (DT_FRAC - 1);
    localparam logic [PW:0] CAP_P  = (PW + 1)'(1) << CAP_SHIFT;
    localparam logic [DIV_STEPS-1:0] CAP_Q = DIV_STEPS'(1) << CAP_SHIFT;

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;
    localparam logic [1:0] U_FIN  = 2'd3;

    logic [1:0]          mode_reg, mode_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [AW-1:0]       a_reg, a_next;
    logic [DT_FRAC-1:0]  dv_reg, dv_next;
    logic [DT_FRAC-1:0]  rem_reg, rem_next;
    logic                frac_reg, frac_next;
    logic                div_reg, div_next;
    logic [AW-1:0]       mag_reg, mag_next;

    logic [AW:0]         mul_sum;
    logic [DT_FRAC:0]    div_r2;
    logic [DT_FRAC:0]    div_sub;
    logic                div_ge;
    logic [PW:0]         rnd_f, rnd_t, shf;
    logic [DIV_STEPS-1:0] quo;

    always_comb begin
        mul_sum = {1'b0, p_reg[PW-1:BW]} + (p_reg[0] ? {1'b0, a_reg} : {(AW + 1){1'b0}});
        div_r2  = {rem_reg, p_reg[DIV_STEPS-1]};
        div_ge  = div_r2 >= {1'b0, dv_reg};
        div_sub = div_r2 - {1'b0, dv_reg};
        rnd_f   = {1'b0, p_reg} + HALF_F;
        rnd_t   = {1'b0, p_reg} + HALF_T;
        shf     = frac_reg ? (rnd_f >> FRAC_BITS) : (rnd_t >> DT_FRAC);
        quo     = p_reg[DIV_STEPS-1:0];
    end

    always_comb begin
        mode_next = mode_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        p_next    = p_reg;
        a_next    = a_reg;
        dv_next   = dv_reg;
        rem_next  = rem_reg;
        frac_next = frac_reg;
        div_next  = div_reg;
        mag_next  = mag_reg;
        case (mode_reg)
            U_IDLE: begin
                if (req.start) begin
                    div_next  = req.divide;
                    frac_next = req.frac_shift;
                    a_next    = req.a_mag;
                    dv_next   = req.b_mag[DT_FRAC-1:0];
                    rem_next  = '0;
                    if (req.divide) begin
                        p_next    = {{(PW - DIV_STEPS){1'b0}}, req.a_mag, {DT_FRAC{1'b0}}};
                        cnt_next  = CNT_W'(DIV_STEPS);
                        mode_next = U_DIV;
                    end else begin
                        p_next    = {{AW{1'b0}}, req.b_mag};
                        cnt_next  = CNT_W'(BW);
                        mode_next = U_MUL;
                    end
                end
            end
            U_MUL: begin
                p_next   = {mul_sum, p_reg[BW-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    mode_next = U_FIN;
                end
            end
            U_DIV: begin
                p_next   = {p_reg[PW-2:0], div_ge};
                rem_next = div_ge ? div_sub[DT_FRAC-1:0] : div_r2[DT_FRAC-1:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    mode_next = U_FIN;
                end
            end
            U_FIN: begin
                if (div_reg) begin
                    mag_next = (quo > CAP_Q) ? CAP_Q[AW-1:0] : quo[AW-1:0];
                end else begin
                    mag_next = (shf > CAP_P) ? CAP_P[AW-1:0] : shf[AW-1:0];
                end
                done_next = 1'b1;
                mode_next = U_IDLE;
            end
            default: begin
                mode_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= U_IDLE;
            done_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        p_reg    <= p_next;
        a_reg    <= a_next;
        dv_reg   <= dv_next;
        rem_reg  <= rem_next;
        frac_reg <= frac_next;
        div_reg  <= div_next;
        mag_reg  <= mag_next;
    end

    assign rsp.done = done_reg;
    assign rsp.mag  = mag_reg;

endmodule
`default_nettype wire
